// File: src/dedg_pkg.sv
// dedg_pkg: shared types and constants of the 3x3 depth edge classifier
// no dependencies; imported by dedg_pos_ctr, dedg_classify and the core

package dedg_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int DEPTH_BITS = 16;
	localparam int COL_W      = 10;
	localparam int ROW_W      = 12;
	localparam int FW_W       = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int MAX_HEIGHT = 4095;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP         = 2'd3;

	// pixel classes
	localparam logic [1:0] CLASS_SKIP = 2'd0;
	localparam logic [1:0] CLASS_FLAT = 2'd1;
	localparam logic [1:0] CLASS_EDGE = 2'd2;

	// one stored depth sample: measurement flag above the depth
	typedef struct packed {
		logic                  vld;
		logic [DEPTH_BITS-1:0] depth;
	} sample_t;

	localparam int SAMPLE_W = $bits(sample_t);

	typedef struct packed {
		logic [DEPTH_BITS-1:0] depth_mm;
		logic                  depth_valid;
	} in_req_t;

	typedef struct packed {
		logic [1:0]       pixel_class;
		logic [ROW_W-1:0] center_row;
		logic [COL_W-1:0] center_col;
		logic             frame_last;
	} out_req_t;

	// raster position of a sample and what it completes
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             emit;
		logic             last;
	} pos_t;

endpackage

// File: src/dedg_line_ram.sv
// dedg_line_ram: generic one-read one-write line memory with registered read data
// no package dependency

module dedg_line_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 17,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/dedg_pos_ctr.sv
// dedg_pos_ctr: raster row and column counters of the incoming sample stream
// depends on dedg_pkg

module dedg_pos_ctr import dedg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic [COL_W-1:0] col_last,
	input  logic [ROW_W-1:0] row_last,
	output pos_t             pos
);

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (adv) begin
			if (col_q >= col_last) begin
				col_q <= '0;
				row_q <= (row_q >= row_last) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_comb begin
		pos.row  = row_q;
		pos.col  = col_q;
		pos.emit = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
		pos.last = (row_q == row_last) && (col_q == col_last);
	end

endmodule

// File: src/dedg_classify.sv
// dedg_classify: skip / flat / edge decision for one complete 3x3 window
// depends on dedg_pkg

module dedg_classify import dedg_pkg::*; (
	input  sample_t               center,
	input  sample_t               nbr [8],
	input  logic [DEPTH_BITS-1:0] max_depth,
	input  logic [DEPTH_BITS-1:0] step,
	output logic [1:0]            pixel_class
);

	logic [7:0]                   nbr_missing;
	logic [7:0]                   nbr_step;
	logic signed [DEPTH_BITS+1:0] diff [8];

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			nbr_missing[k] = !nbr[k].vld;
			diff[k] = $signed({2'b00, center.depth}) - $signed({2'b00, nbr[k].depth});
			nbr_step[k] = diff[k] > $signed({2'b00, step});
		end
	end

	always_comb begin
		priority if (!center.vld || !(center.depth < max_depth)) begin
			pixel_class = CLASS_SKIP;
		end else if ((|nbr_missing) || (|nbr_step)) begin
			pixel_class = CLASS_EDGE;
		end else begin
			pixel_class = CLASS_FLAT;
		end
	end

endmodule

// File: src/depth_edge_detect_3x3_core.sv
// depth_edge_detect_3x3_core: top level of the 3x3 depth discontinuity classifier
// depends on dedg_pkg, dedg_line_ram, dedg_pos_ctr, dedg_classify

// Depth samples enter in raster order, one request per clock while ready, and
// each interior pixel leaves as one result request (skipped, flat or edge) via
// the input stage and the output register once the sample below and right of it
// is taken; border pixels give no result. Sustained rate is one sample per cycle
// while results are accepted, set by the one read port and one write port of
// each line memory: a sample reads both lines at its column when taken and
// writes them back when it leaves the input stage. The input stage (taken sample
// and line read data) and the output register keep the sides apart, so a stalled
// result does not block a sample from being taken while the input stage is free.
// Line memories have no reset and need no clearing pass: reads in a frame's
// first two rows never reach a result. Configuration is to be written by the
// user only while the block is idle; the block does not enforce it.

module depth_edge_detect_3x3_core import dedg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// depth sample requests
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  in_req_t               sample,
	// classification result requests
	output logic                  result_valid,
	input  logic                  result_ready,
	output out_req_t              result,
	// configuration writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// configuration registers
	logic [FW_W-1:0]       frame_width_q;
	logic [ROW_W-1:0]      frame_height_q;
	logic [DEPTH_BITS-1:0] max_depth_q;
	logic [DEPTH_BITS-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_W'(640);
			frame_height_q <= ROW_W'(480);
			max_depth_q    <= DEPTH_BITS'(4000);
			step_q         <= DEPTH_BITS'(100);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata[ROW_W-1:0];
				REG_MAX_DEPTH:    max_depth_q    <= cfg_wdata[DEPTH_BITS-1:0];
				REG_STEP:         step_q         <= cfg_wdata[DEPTH_BITS-1:0];
				default:          ;
			endcase
		end
	end

	// last column and last row after clamping the geometry to its legal range
	logic [COL_W-1:0] col_last;
	logic [ROW_W-1:0] row_last;

	always_comb begin
		priority if (frame_width_q < FW_W'(3)) begin
			col_last = COL_W'(2);
		end else if (frame_width_q > FW_W'(MAX_WIDTH)) begin
			col_last = COL_W'(MAX_WIDTH - 1);
		end else begin
			col_last = COL_W'(frame_width_q - 1'b1);
		end
		priority if (frame_height_q < ROW_W'(3)) begin
			row_last = ROW_W'(2);
		end else if (frame_height_q > ROW_W'(MAX_HEIGHT)) begin
			row_last = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			row_last = frame_height_q - 1'b1;
		end
	end

	// handshake control
	logic valid_s1;
	logic s1_adv;
	logic out_free;
	logic in_fire;

	assign out_free     = !result_valid || result_ready;
	assign s1_adv       = valid_s1 && out_free;
	assign sample_ready = !valid_s1 || s1_adv;
	assign in_fire      = sample_valid && sample_ready;

	// position of the incoming sample
	pos_t pos_cur;

	dedg_pos_ctr u_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (in_fire),
		.col_last (col_last),
		.row_last (row_last),
		.pos      (pos_cur)
	);

	// stage 1: the taken sample, its position, and the line reads issued with it
	pos_t    pos_s1;
	sample_t cur_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pos_s1     <= pos_cur;
			cur_s1.vld <= sample.depth_valid;
			cur_s1.depth <= sample.depth_mm;
		end
	end

	// line memories: upper holds the row two back, middle the row one back
	sample_t up_s1;
	sample_t mid_s1;

	dedg_line_ram #(
		.DEPTH (MAX_WIDTH),
		.WIDTH (SAMPLE_W)
	) u_line_upper (
		.clk   (clk),
		.re    (in_fire),
		.raddr (pos_cur.col),
		.rdata (up_s1),
		.we    (s1_adv),
		.waddr (pos_s1.col),
		.wdata (mid_s1)
	);

	dedg_line_ram #(
		.DEPTH (MAX_WIDTH),
		.WIDTH (SAMPLE_W)
	) u_line_middle (
		.clk   (clk),
		.re    (in_fire),
		.raddr (pos_cur.col),
		.rdata (mid_s1),
		.we    (s1_adv),
		.waddr (pos_s1.col),
		.wdata (cur_s1)
	);

	// window: two previous columns, three rows each; entry 4 is the center
	sample_t win_q [6];

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= up_s1;
			win_q[4] <= mid_s1;
			win_q[5] <= cur_s1;
		end
	end

	// the eight neighbors of the center, in any order
	sample_t    nbr [8];
	logic [1:0] cls;

	always_comb begin
		nbr[0] = win_q[0];
		nbr[1] = win_q[1];
		nbr[2] = win_q[2];
		nbr[3] = win_q[3];
		nbr[4] = win_q[5];
		nbr[5] = up_s1;
		nbr[6] = mid_s1;
		nbr[7] = cur_s1;
	end

	dedg_classify u_cls (
		.center      (win_q[4]),
		.nbr         (nbr),
		.max_depth   (max_depth_q),
		.step        (step_q),
		.pixel_class (cls)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (s1_adv && pos_s1.emit) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && pos_s1.emit) begin
			result.pixel_class <= cls;
			result.center_row  <= pos_s1.row - 1'b1;
			result.center_col  <= pos_s1.col - 1'b1;
			result.frame_last  <= pos_s1.last;
		end
	end

	// checks
	a_take_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> valid_s1)
		else $error("taken sample did not reach stage 1");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> valid_s1 && $stable(pos_s1) && $stable(cur_s1))
		else $error("stalled stage 1 changed");

	a_result_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(valid_s1))
		else $error("result appeared without a stage 1 sample");

	a_interior_only: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.center_row != '0 && result.center_col != '0)
		else $error("result on a border pixel");

endmodule
